// ===== rtl/pate_pkg.sv =====
// ============================================================================
// pate_pkg - shared types and constants for the positional array table engine
// Item and result structs, operation and status codes, cell commands, FSM states.
// ============================================================================
package pate_pkg;

    localparam int DEPTH_DEF = 64;
    localparam int WORD_W    = 32;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_DELETE = 2'd1,
        OP_SEARCH = 2'd2,
        OP_SORTED = 2'd3
    } t_op;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BADPOS   = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;
    localparam logic [1:0] ST_NOTFOUND = 2'd3;

    typedef struct packed {
        t_op                       operation;
        logic [6:0]                position;
        logic signed [WORD_W-1:0]  value;
    } t_in_item;

    typedef struct packed {
        logic [1:0] status;
        logic [5:0] found_index;
        logic [6:0] entry_count;
    } t_out_item;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_INS,
        CELL_DEL,
        CELL_CMP_EQ,
        CELL_CMP_GT,
        CELL_SHIFT
    } t_cell_op;

    typedef struct packed {
        t_cell_op                  op;
        logic signed [WORD_W-1:0]  word;
    } t_cell_cmd;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DECIDE,
        S_SCAN
    } t_state;

endpackage

// ===== rtl/pate_cell.sv =====
// ============================================================================
// pate_cell - one slot of the table
// Holds one entry and one match flag; shifts with its neighbors on command.
// ============================================================================
module pate_cell #(
    parameter int INDEX = 0,
    parameter int IW    = 6
) (
    input  logic                                  i_clk,
    input  pate_pkg::t_cell_cmd                   i_cmd,
    input  logic [IW-1:0]                         i_idx,
    input  logic signed [pate_pkg::WORD_W-1:0]    i_left_entry,
    input  logic signed [pate_pkg::WORD_W-1:0]    i_right_entry,
    input  logic                                  i_right_flag,
    output logic signed [pate_pkg::WORD_W-1:0]    o_entry,
    output logic                                  o_flag
);
    import pate_pkg::*;

    logic signed [WORD_W-1:0] r_entry, n_entry;
    logic                     r_flag, n_flag;
    logic [IW-1:0]            w_my_idx;

    assign w_my_idx = IW'(INDEX);

    always_comb begin
        n_entry = r_entry;
        n_flag  = r_flag;
        case (i_cmd.op)
            CELL_INS: begin
                if (w_my_idx > i_idx) begin
                    n_entry = i_left_entry;
                end else if (w_my_idx == i_idx) begin
                    n_entry = i_cmd.word;
                end
            end
            CELL_DEL: begin
                if (w_my_idx >= i_idx) begin
                    n_entry = i_right_entry;
                end
            end
            CELL_CMP_EQ: n_flag = (r_entry == i_cmd.word);
            CELL_CMP_GT: n_flag = (r_entry > i_cmd.word);
            CELL_SHIFT:  n_flag = i_right_flag;
            default: begin
                n_entry = r_entry;
                n_flag  = r_flag;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
        r_flag  <= n_flag;
    end

    assign o_entry = r_entry;
    assign o_flag  = r_flag;

endmodule

// ===== rtl/pate_ctrl.sv =====
// ============================================================================
// pate_ctrl - command sequencer for the table
// Checks positions and fill, drives cell commands, walks the flag chain.
// ============================================================================
module pate_ctrl #(
    parameter int DEPTH = pate_pkg::DEPTH_DEF,
    parameter int IW    = $clog2(DEPTH)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    input  pate_pkg::t_in_item    i_item,
    output logic                  busy,
    output logic                  o_done,
    output pate_pkg::t_out_item   o_result,
    output pate_pkg::t_cell_cmd   o_cell_cmd,
    output logic [IW-1:0]         o_cell_idx,
    input  logic                  i_head_flag
);
    import pate_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);
    localparam int WW = ((CW > 7) ? CW : 7) + 1;

    t_state                   r_state, n_state;
    t_op                      r_op, n_op;
    logic [6:0]               r_pos, n_pos;
    logic signed [WORD_W-1:0] r_key, n_key;
    logic [CW-1:0]            r_count, n_count;
    logic [CW-1:0]            r_step, n_step;
    logic                     r_done, n_done;
    t_out_item                r_result, n_result;

    logic [WW-1:0] w_pos;
    logic [WW-1:0] w_cnt;
    logic          w_full;

    assign w_pos  = WW'(r_pos);
    assign w_cnt  = WW'(r_count);
    assign w_full = (r_count == CW'(DEPTH));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op     <= n_op;
        r_pos    <= n_pos;
        r_key    <= n_key;
        r_step   <= n_step;
        r_result <= n_result;
    end

    always_comb begin
        n_state         = r_state;
        n_op            = r_op;
        n_pos           = r_pos;
        n_key           = r_key;
        n_count         = r_count;
        n_step          = r_step;
        n_done          = 1'b0;
        n_result        = r_result;
        o_cell_cmd.op   = CELL_HOLD;
        o_cell_cmd.word = r_key;
        o_cell_idx      = '0;

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_op    = i_item.operation;
                    n_pos   = i_item.position;
                    n_key   = i_item.value;
                    n_state = S_DECIDE;
                end
            end

            S_DECIDE: begin
                n_result.found_index = '0;
                case (r_op)
                    OP_INSERT: begin
                        n_done  = 1'b1;
                        n_state = S_IDLE;
                        if (w_pos == '0 || w_pos > w_cnt + WW'(1)) begin
                            n_result.status = ST_BADPOS;
                        end else if (w_full) begin
                            n_result.status = ST_FULL;
                        end else begin
                            o_cell_cmd.op   = CELL_INS;
                            o_cell_idx      = IW'(r_pos - 7'd1);
                            n_count         = r_count + CW'(1);
                            n_result.status = ST_OK;
                        end
                    end
                    OP_DELETE: begin
                        n_done  = 1'b1;
                        n_state = S_IDLE;
                        if (w_pos == '0 || w_pos > w_cnt) begin
                            n_result.status = ST_BADPOS;
                        end else begin
                            o_cell_cmd.op   = CELL_DEL;
                            o_cell_idx      = IW'(r_pos - 7'd1);
                            n_count         = r_count - CW'(1);
                            n_result.status = ST_OK;
                        end
                    end
                    OP_SEARCH: begin
                        o_cell_cmd.op = CELL_CMP_EQ;
                        n_step        = '0;
                        n_state       = S_SCAN;
                    end
                    default: begin
                        // sorted insert
                        if (w_full) begin
                            n_done          = 1'b1;
                            n_state         = S_IDLE;
                            n_result.status = ST_FULL;
                        end else begin
                            o_cell_cmd.op = CELL_CMP_GT;
                            n_step        = '0;
                            n_state       = S_SCAN;
                        end
                    end
                endcase
                n_result.entry_count = 7'(n_count);
            end

            S_SCAN: begin
                n_result.found_index = '0;
                if (r_step == r_count || i_head_flag) begin
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                    if (r_op == OP_SEARCH) begin
                        if (r_step == r_count) begin
                            n_result.status = ST_NOTFOUND;
                        end else begin
                            n_result.status      = ST_OK;
                            n_result.found_index = 6'(r_step);
                        end
                    end else begin
                        // append at end, or in front of first greater entry
                        o_cell_cmd.op   = CELL_INS;
                        o_cell_idx      = IW'(r_step);
                        n_count         = r_count + CW'(1);
                        n_result.status = ST_OK;
                    end
                end else begin
                    o_cell_cmd.op = CELL_SHIFT;
                    n_step        = r_step + CW'(1);
                end
                n_result.entry_count = 7'(n_count);
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign busy     = (r_state != S_IDLE);
    assign o_done   = r_done;
    assign o_result = r_result;

endmodule

// ===== rtl/positional_array_table_engine_top.sv =====
// ============================================================================
// positional_array_table_engine_top - dense list of signed words
// Positional insert/delete, linear search and sorted insert over a cell chain.
// ============================================================================
// An item is taken when start is high and busy is low. Positional insert and
// delete hold busy only through the decide state: every cell compares its own
// slot index to the target and shifts with its neighbor in parallel at the
// edge that ends it. Search and sorted insert hold busy through the decide
// state and then the scan state. All cells compare against the key at once
// in the decide state. The match flags then ride down the chain one cell per
// cycle toward cell 0, and the sequencer counts steps until a flag arrives or
// the count of valid entries is reached. That flag walk sets the item time. A
// sorted insert into a full table skips the walk and returns from the decide
// state. The result is on o_result with o_done high for exactly one cycle, the
// first cycle in which busy is low again. It cannot be held off, so the
// receiver must take it then. A new item may be started in that same cycle.
// Bad positions and a full table return a status and leave the list unchanged.
// ============================================================================
module positional_array_table_engine_top #(
    parameter int DEPTH = pate_pkg::DEPTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    input  pate_pkg::t_in_item    i_item,
    output logic                  busy,
    output logic                  o_done,
    output pate_pkg::t_out_item   o_result
);
    import pate_pkg::*;

    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    // Shared command broadcast to every cell
    t_cell_cmd                w_cell_cmd;
    logic [IW-1:0]            w_cell_idx;

    // Neighbor links along the chain
    logic signed [WORD_W-1:0] w_entry [DEPTH];
    logic                     w_flag  [DEPTH];

    pate_ctrl #(
        .DEPTH (DEPTH),
        .IW    (IW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .i_item      (i_item),
        .busy        (busy),
        .o_done      (o_done),
        .o_result    (o_result),
        .o_cell_cmd  (w_cell_cmd),
        .o_cell_idx  (w_cell_idx),
        .i_head_flag (w_flag[0])
    );

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++) begin : g_cell
            logic signed [WORD_W-1:0] w_left;
            logic signed [WORD_W-1:0] w_right;
            logic                     w_right_flag;

            // Cell 0 never takes from the left; the last cell sees its own entry and a
            // cleared flag on the right (its content is past the count anyway).
            if (g == 0) begin : g_first
                assign w_left = w_cell_cmd.word;
            end else begin : g_mid_l
                assign w_left = w_entry[g-1];
            end

            if (g == DEPTH - 1) begin : g_last
                assign w_right      = w_entry[g];
                assign w_right_flag = 1'b0;
            end else begin : g_mid_r
                assign w_right      = w_entry[g+1];
                assign w_right_flag = w_flag[g+1];
            end

            pate_cell #(
                .INDEX (g),
                .IW    (IW)
            ) u_cell (
                .i_clk         (i_clk),
                .i_cmd         (w_cell_cmd),
                .i_idx         (w_cell_idx),
                .i_left_entry  (w_left),
                .i_right_entry (w_right),
                .i_right_flag  (w_right_flag),
                .o_entry       (w_entry[g]),
                .o_flag        (w_flag[g])
            );
        end
    endgenerate

endmodule
